// ===== sv/cbh_pkg.sv =====
// Shared types and constants for the character bigram histogram unit.
// No dependencies; imported by char_bigram_histogram_unit.
`timescale 1ns / 1ps
`default_nettype none

package cbh_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned CHAR_BITS  = 8;
  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned SHOWN_BITS = 16;
  localparam int unsigned TOTAL_BITS = 24;
  localparam int unsigned RATIO_BITS = 17;
  localparam int unsigned IN_DATA_BITS  = 16;
  localparam int unsigned OUT_DATA_BITS = 64;

  // Divider: one quotient bit beyond Q0.16, then round half up
  localparam int unsigned QUOT_BITS = 17;
  localparam int unsigned STEP_BITS = $clog2(QUOT_BITS);

  localparam logic [SHOWN_BITS-1:0] SHOWN_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(65536);

  // Case folding of 'A'..'Z'
  localparam logic [CHAR_BITS-1:0] UPPER_A     = 8'd65;
  localparam logic [CHAR_BITS-1:0] UPPER_Z     = 8'd90;
  localparam logic [CHAR_BITS-1:0] CASE_OFFSET = 8'd32;

  // Item kinds carried on tuser
  typedef enum logic [MODE_BITS-1:0] {
    MODE_FEED  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  // Control sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== sv/char_bigram_histogram_unit.sv =====
// Character bigram histogram: pair and row count stores, update sequencer,
// bit-serial rounding divider and output register. Depends on cbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Counts adjacent character pairs (letters folded to lower case) in a text
// stream and answers pair queries with count, row total and a Q1.16 ratio.
// After reset the block sweeps both stores to zero, one pair entry per cycle;
// s_axis_tready stays low until the sweep is done. One item is in work at a
// time. A feed item that closes a pair does a registered read of both stores,
// then a write back of the saturated increments; other feed and line-start
// items only update the line chain. A query does a lookup, 17 one-bit restoring
// divide steps, and the load into the output register (the divide steps are
// skipped when the total is zero or the count reaches the total). The output
// register lets the next item be taken while a result waits on m_axis_tready.
module char_bigram_histogram_unit
  import cbh_pkg::*;
#(
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // Input stream
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire  [IN_DATA_BITS-1:0]   s_axis_tdata,  // [7:0] char_code, [15:8] second_code
  input  wire  [MODE_BITS-1:0]      s_axis_tuser,  // [1:0] mode
  // Result stream
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,  // [15:0] pair_count, [39:16] row_total,
                                                   // [56:40] ratio, [63:57] zero
  output logic                      m_axis_tuser   // [0] no_data
);

  localparam int unsigned PAIR_ADDR_BITS = 2 * SYMBOL_BITS;
  localparam int unsigned PAIR_DEPTH     = 2 ** PAIR_ADDR_BITS;
  localparam int unsigned ROW_DEPTH      = 2 ** SYMBOL_BITS;
  localparam int unsigned CMP_BITS       = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
  localparam int unsigned PAD_BITS       = OUT_DATA_BITS - SHOWN_BITS - TOTAL_BITS - RATIO_BITS;

  // Fold to the symbol width, then 'A'..'Z' to lower case
  function automatic logic [SYMBOL_BITS-1:0] fold_sym(input logic [CHAR_BITS-1:0] code);
    logic [SYMBOL_BITS-1:0] c;
    c = code[SYMBOL_BITS-1:0];
    if (c >= SYMBOL_BITS'(UPPER_A) && c <= SYMBOL_BITS'(UPPER_Z)) begin
      c = c + SYMBOL_BITS'(CASE_OFFSET);
    end
    return c;
  endfunction

  // Stores
  logic [COUNT_BITS-1:0] pair_mem [PAIR_DEPTH];
  logic [TOTAL_BITS-1:0] row_mem  [ROW_DEPTH];

  state_e state_q, state_d;

  logic [PAIR_ADDR_BITS-1:0] clr_cnt_q;
  logic [SYMBOL_BITS-1:0]    prev_char_q;
  logic                      prev_valid_q;
  logic [PAIR_ADDR_BITS-1:0] pair_waddr_q;
  logic [SYMBOL_BITS-1:0]    row_waddr_q;
  logic [COUNT_BITS-1:0]     pair_rd_q;
  logic [TOTAL_BITS-1:0]     row_rd_q;

  // Divider state
  logic [TOTAL_BITS-1:0]     tot_q;
  logic [TOTAL_BITS-1:0]     rem_q;
  logic [QUOT_BITS-1:0]      quot_q;
  logic [STEP_BITS-1:0]      step_q;
  logic [SHOWN_BITS-1:0]     shown_q;
  logic                      no_data_q;
  logic                      full_q;

  // Output register
  logic                      m_valid_q;
  logic [SHOWN_BITS-1:0]     out_count_q;
  logic [TOTAL_BITS-1:0]     out_total_q;
  logic [RATIO_BITS-1:0]     out_ratio_q;
  logic                      out_no_data_q;

  logic                      in_acc;
  logic                      out_load;
  logic [SYMBOL_BITS-1:0]    sym_a;
  logic [SYMBOL_BITS-1:0]    sym_b;
  logic [PAIR_ADDR_BITS-1:0] pair_raddr;
  logic [SYMBOL_BITS-1:0]    row_raddr;
  logic                      pair_we;
  logic [PAIR_ADDR_BITS-1:0] pair_wa;
  logic [COUNT_BITS-1:0]     pair_wd;
  logic [SYMBOL_BITS-1:0]    row_wa;
  logic [TOTAL_BITS-1:0]     row_wd;
  logic [CMP_BITS-1:0]       cnt_ext;
  logic [CMP_BITS-1:0]       tot_ext;
  logic [TOTAL_BITS:0]       rem_dbl;
  logic                      quot_bit;
  logic [RATIO_BITS:0]       ratio_rnd;
  logic [RATIO_BITS-1:0]     ratio_val;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign sym_a  = fold_sym(s_axis_tdata[CHAR_BITS-1:0]);
  assign sym_b  = fold_sym(s_axis_tdata[IN_DATA_BITS-1:CHAR_BITS]);

  // Read addresses: a feed reads the pair it closes, a query the pair asked for
  always_comb begin
    if (s_axis_tuser == MODE_QUERY) begin
      pair_raddr = {sym_a, sym_b};
      row_raddr  = sym_a;
    end else begin
      pair_raddr = {prev_char_q, sym_a};
      row_raddr  = prev_char_q;
    end
  end

  // Write port: clearing sweep or saturating write back
  always_comb begin
    pair_we = 1'b0;
    pair_wa = pair_waddr_q;
    row_wa  = row_waddr_q;
    pair_wd = (pair_rd_q == '1) ? pair_rd_q : pair_rd_q + COUNT_BITS'(1);
    row_wd  = (row_rd_q == TOTAL_MAX) ? row_rd_q : row_rd_q + TOTAL_BITS'(1);
    if (state_q == ST_CLEAR) begin
      pair_we = 1'b1;
      pair_wa = clr_cnt_q;
      row_wa  = clr_cnt_q[SYMBOL_BITS-1:0];
      pair_wd = '0;
      row_wd  = '0;
    end else if (state_q == ST_UPDATE) begin
      pair_we = 1'b1;
    end
  end

  // Pair count store
  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    if (in_acc) begin
      pair_rd_q <= pair_mem[pair_raddr];
    end
  end

  // Row total store
  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (in_acc) begin
      row_rd_q <= row_mem[row_raddr];
    end
  end

  // Divider step: shift the partial remainder, subtract the total if it fits
  assign cnt_ext  = CMP_BITS'(pair_rd_q);
  assign tot_ext  = CMP_BITS'(row_rd_q);
  assign rem_dbl  = {rem_q, 1'b0};
  assign quot_bit = (rem_dbl >= {1'b0, tot_q});

  // Round half up from the doubled quotient
  assign ratio_rnd = {1'b0, quot_q} + (RATIO_BITS + 1)'(1);
  always_comb begin
    if (no_data_q) begin
      ratio_val = '0;
    end else if (full_q) begin
      ratio_val = RATIO_ONE;
    end else begin
      ratio_val = ratio_rnd[RATIO_BITS:1];
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == MODE_QUERY) begin
            state_d = ST_LOOKUP;
          end else if (s_axis_tuser == MODE_FEED && prev_valid_q) begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      ST_LOOKUP: begin
        if (row_rd_q == '0 || cnt_ext >= tot_ext) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step_q == STEP_BITS'(QUOT_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers: sweep counter, line chain, divide step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      prev_char_q  <= '0;
      prev_valid_q <= 1'b0;
      step_q       <= '0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + PAIR_ADDR_BITS'(1);
      end
      if (in_acc) begin
        if (s_axis_tuser == MODE_FEED) begin
          prev_char_q  <= sym_a;
          prev_valid_q <= 1'b1;
        end else if (s_axis_tuser == MODE_LINE) begin
          prev_valid_q <= 1'b0;
        end
      end
      if (state_q == ST_DIVIDE) begin
        step_q <= step_q + STEP_BITS'(1);
      end else begin
        step_q <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pair_waddr_q <= pair_raddr;
      row_waddr_q  <= row_raddr;
    end
    if (state_q == ST_LOOKUP) begin
      tot_q     <= row_rd_q;
      rem_q     <= TOTAL_BITS'(cnt_ext);
      quot_q    <= '0;
      shown_q   <= (cnt_ext > CMP_BITS'(SHOWN_MAX)) ? SHOWN_MAX : cnt_ext[SHOWN_BITS-1:0];
      no_data_q <= (row_rd_q == '0);
      full_q    <= (cnt_ext >= tot_ext);
    end else if (state_q == ST_DIVIDE) begin
      rem_q  <= quot_bit ? TOTAL_BITS'(rem_dbl - {1'b0, tot_q}) : rem_dbl[TOTAL_BITS-1:0];
      quot_q <= {quot_q[QUOT_BITS-2:0], quot_bit};
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q   <= shown_q;
      out_total_q   <= tot_q;
      out_ratio_q   <= ratio_val;
      out_no_data_q <= no_data_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {PAD_BITS'(0), out_ratio_q, out_total_q, out_count_q};
  assign m_axis_tuser  = out_no_data_q;

endmodule

`default_nettype wire
